// ----- rtl/wwg_pkg.sv -----
// ----------------------------------------------------------------------------
// wwg_pkg
// Shared types and codes of the wireworld grid engine: cell states, command
// codes, register indexes, controller states and the window control bundle.
// ----------------------------------------------------------------------------
package wwg_pkg;

   typedef logic [1:0] cell_type;
   typedef logic [1:0] cmd_type;

   localparam cell_type CELL_EMPTY = 2'd0;
   localparam cell_type CELL_WIRE  = 2'd1;
   localparam cell_type CELL_HEAD  = 2'd2;
   localparam cell_type CELL_TAIL  = 2'd3;

   localparam cmd_type CMD_WRITE = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_RUN   = 2'd2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'd1;

   localparam logic [7:0] COLS_RESET = 8'd128;
   localparam logic [4:0] ROWS_RESET = 5'd16;

   localparam int DEF_MAX_ROWS = 16;
   localparam int DEF_MAX_COLS = 128;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_READ,
      FSM_RUN,
      FSM_DRAIN,
      FSM_DONE
   } fsm_state_type;

   typedef struct packed {
      logic shift;
      logic restart;
      logic top_ok;
      logic bot_ok;
      logic at_edge;
   } win_ctl_type;

endpackage

// ----- rtl/wwg_if.sv -----
// ----------------------------------------------------------------------------
// wwg_if
// Valid/ready channels of the wireworld grid engine: command beats in,
// response beats out.
// ----------------------------------------------------------------------------
interface wwg_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [3:0] row;
   logic [6:0] col;
   logic [1:0] cell_value;
   logic [7:0] generations;

   modport source (output valid, cmd, row, col, cell_value, generations, input ready);
   modport sink   (input valid, cmd, row, col, cell_value, generations, output ready);
endinterface

interface wwg_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] cell_read;
   logic       status;

   modport source (output valid, cell_read, status, input ready);
   modport sink   (input valid, cell_read, status, output ready);
endinterface

// ----- rtl/wireworld_grid_engine.sv -----
// ----------------------------------------------------------------------------
// wireworld_grid_engine
// Wireworld cellular automaton held in a synchronous cell memory.
//
// Commands arrive as beats on req_ch: write one cell, read one cell, or run a
// number of generations over the active rows and columns set by the csr_
// registers. Every command returns exactly one beat on rsp_ch with the cell
// read (zero otherwise) and a status flag set for a coordinate outside the
// active grid. Commands are taken one at a time.
// A run reads one cell per cycle through the cell memory read port, with one
// lead-in row per generation to prime the row history and a flush state
// after each generation.
// The response sits in an output register; a new command is taken while an
// earlier response still waits, and the engine holds the next response until
// the receiver has taken the previous one.
// After reset the cell memory is swept to empty, one entry per cycle, over
// MAX_ROWS rounded up to a power of two times MAX_COLS rounded likewise
// entries (2048 at the defaults); no command is taken meanwhile, register
// writes are.
// ----------------------------------------------------------------------------
module wireworld_grid_engine
   import wwg_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
)
(
   input  logic                  clock,
   input  logic                  reset,
   wwg_req_if.sink               req_ch,
   wwg_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RA     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CA     = $clog2(MAX_COLS);
   localparam int AW     = RA + CA;
   localparam int ROW_CW = $clog2(MAX_ROWS + 1);
   localparam int COL_CW = $clog2(MAX_COLS + 1);
   localparam int RC_W   = (ROW_CW > 5) ? ROW_CW : 5;
   localparam int CC_W   = (COL_CW > 8) ? COL_CW : 8;

   // configuration
   logic [7:0]        cols_ff;
   logic [4:0]        rows_ff;
   logic [COL_CW-1:0] ncols;
   logic [ROW_CW-1:0] nrows;
   logic [CC_W-1:0]   cols_x;
   logic [RC_W-1:0]   rows_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLS: cols_ff <= csr_wdata;
            CSR_ROWS: rows_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cols_x = CC_W'(cols_ff);
      if (cols_x == '0) cols_x = CC_W'(1);
      else if (cols_x > CC_W'(MAX_COLS)) cols_x = CC_W'(MAX_COLS);
      rows_x = RC_W'(rows_ff);
      if (rows_x == '0) rows_x = RC_W'(1);
      else if (rows_x > RC_W'(MAX_ROWS)) rows_x = RC_W'(MAX_ROWS);
      ncols = COL_CW'(cols_x);
      nrows = ROW_CW'(rows_x);
   end

   // controller
   fsm_state_type state_ff, state_in;
   logic          acc;
   logic          in_range;
   logic          req_ready;
   logic          run_issue;
   logic          clr_we;
   logic          done_load;
   logic          row_last;
   logic          col_end;
   logic          gen_end;

   logic [AW-1:0]     clr_addr_ff;
   logic              prime_ff;
   logic [RA-1:0]     row_ff;
   logic [COL_CW-1:0] col_ff;
   logic [7:0]        gen_left_ff;

   logic              s1_valid_ff;
   logic              s1_prime_ff;
   logic [RA-1:0]     s1_row_ff;
   logic [COL_CW-1:0] s1_col_ff;

   cell_type pend_cell_ff;
   logic     pend_status_ff;
   logic     rsp_valid_ff;
   cell_type rsp_cell_ff;
   logic     rsp_status_ff;

   assign acc      = req_ch.valid && req_ready;
   assign in_range = (RC_W'(req_ch.row) < RC_W'(nrows)) && (CC_W'(req_ch.col) < CC_W'(ncols));
   assign row_last = (ROW_CW'(row_ff) + ROW_CW'(1)) == nrows;
   assign col_end  = col_ff == ncols;
   assign gen_end  = run_issue && col_end && !prime_ff && row_last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_CLEAR: if (clr_addr_ff == '1) state_in = FSM_IDLE;
         FSM_IDLE: begin
            if (acc) begin
               case (req_ch.cmd)
                  CMD_READ: state_in = in_range ? FSM_READ : FSM_DONE;
                  CMD_RUN:  state_in = (req_ch.generations == 8'd0) ? FSM_DONE : FSM_RUN;
                  default:  state_in = FSM_DONE;
               endcase
            end
         end
         FSM_READ:  state_in = FSM_DONE;
         FSM_RUN:   if (gen_end) state_in = FSM_DRAIN;
         FSM_DRAIN: state_in = (gen_left_ff == 8'd0) ? FSM_DONE : FSM_RUN;
         FSM_DONE:  if (done_load) state_in = FSM_IDLE;
         default:   state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      run_issue = 1'b0;
      clr_we    = 1'b0;
      done_load = 1'b0;
      case (state_ff)
         FSM_CLEAR: clr_we    = 1'b1;
         FSM_IDLE:  req_ready = 1'b1;
         FSM_RUN:   run_issue = 1'b1;
         FSM_DONE:  done_load = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FSM_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clr_we) clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // generation sequencer: a lead-in row, then each active row, one column a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff    <= 1'b1;
         row_ff      <= '0;
         col_ff      <= '0;
         gen_left_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= run_issue;
         if (acc) begin
            prime_ff    <= 1'b1;
            row_ff      <= '0;
            col_ff      <= '0;
            gen_left_ff <= req_ch.generations;
         end else if (run_issue) begin
            if (col_end) begin
               col_ff <= '0;
               if (prime_ff) begin
                  prime_ff <= 1'b0;
                  row_ff   <= '0;
               end else if (row_last) begin
                  gen_left_ff <= gen_left_ff - 8'd1;
               end else begin
                  row_ff <= row_ff + RA'(1);
               end
            end else begin
               col_ff <= col_ff + COL_CW'(1);
            end
         end else if (state_ff == FSM_DRAIN) begin
            prime_ff <= 1'b1;
            col_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_prime_ff <= prime_ff;
      s1_row_ff   <= row_ff;
      s1_col_ff   <= col_ff;
   end

   // cell memory and row history
   logic [1:0] grid_mem [0:(2**AW)-1];
   logic [3:0] hist_mem [0:(2**CA)-1];
   cell_type   grid_rdata_ff;
   logic [3:0] hist_rdata_ff;

   logic          g_we;
   logic [AW-1:0] g_waddr;
   cell_type      g_wdata;
   logic [AW-1:0] g_raddr;
   logic [RA-1:0] rd_row;
   logic          wb_we;
   logic [COL_CW-1:0] wb_col;
   logic          h_we;
   cell_type      new_cell;
   win_ctl_type   win_ctl;

   assign rd_row = prime_ff ? '0 : row_ff + RA'(1);
   assign wb_col = s1_col_ff - COL_CW'(1);
   assign wb_we  = s1_valid_ff && !s1_prime_ff && (s1_col_ff != '0);
   assign h_we   = s1_valid_ff && (s1_col_ff != ncols);

   always_comb begin
      g_we    = 1'b0;
      g_waddr = {RA'(req_ch.row), CA'(req_ch.col)};
      g_wdata = req_ch.cell_value;
      if (clr_we) begin
         g_we    = 1'b1;
         g_waddr = clr_addr_ff;
         g_wdata = CELL_EMPTY;
      end else if (wb_we) begin
         g_we    = 1'b1;
         g_waddr = {s1_row_ff, wb_col[CA-1:0]};
         g_wdata = new_cell;
      end else if (acc && req_ch.cmd == CMD_WRITE && in_range) begin
         g_we = 1'b1;
      end
      g_raddr = run_issue ? {rd_row, col_ff[CA-1:0]} : {RA'(req_ch.row), CA'(req_ch.col)};
   end

   always_ff @(posedge clock) begin
      if (g_we) grid_mem[g_waddr] <= g_wdata;
      grid_rdata_ff <= grid_mem[g_raddr];
   end

   // history entry: upper half old row at the cell, lower half old row above
   always_ff @(posedge clock) begin
      if (h_we) hist_mem[s1_col_ff[CA-1:0]] <= {grid_rdata_ff, hist_rdata_ff[3:2]};
      hist_rdata_ff <= hist_mem[col_ff[CA-1:0]];
   end

   always_comb begin
      win_ctl.shift   = s1_valid_ff;
      win_ctl.restart = s1_col_ff == '0;
      win_ctl.top_ok  = !s1_prime_ff && (s1_row_ff != '0);
      win_ctl.bot_ok  = !s1_prime_ff && ((ROW_CW'(s1_row_ff) + ROW_CW'(1)) != nrows);
      win_ctl.at_edge = s1_col_ff == ncols;
   end

   wwg_window u_window (
      .clock    (clock),
      .ctl      (win_ctl),
      .top_cell (hist_rdata_ff[1:0]),
      .mid_cell (hist_rdata_ff[3:2]),
      .bot_cell (grid_rdata_ff),
      .new_cell (new_cell)
   );

   // response
   always_ff @(posedge clock) begin
      if (acc) begin
         pend_cell_ff   <= CELL_EMPTY;
         pend_status_ff <= (req_ch.cmd == CMD_WRITE || req_ch.cmd == CMD_READ) && !in_range;
      end else if (state_ff == FSM_READ) begin
         pend_cell_ff <= grid_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_load) begin
         rsp_cell_ff   <= pend_cell_ff;
         rsp_status_ff <= pend_status_ff;
      end
   end

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.cell_read = rsp_cell_ff;
   assign rsp_ch.status    = rsp_status_ff;

   a_wb_in_run: assert property (@(posedge clock) disable iff (reset)
      wb_we |-> (state_ff == FSM_RUN || state_ff == FSM_DRAIN))
      else $error("cell write-back outside a run");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_col_ff <= ncols))
      else $error("column step beyond active width");

   a_drain_flush: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_DRAIN |=> !s1_valid_ff)
      else $error("pipeline not empty after generation flush");

   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      done_load |=> (rsp_valid_ff && state_ff == FSM_IDLE))
      else $error("finished command lost its response beat");

   a_read_path: assert property (@(posedge clock) disable iff (reset)
      (acc && req_ch.cmd == CMD_READ && in_range) |=> state_ff == FSM_READ)
      else $error("cell read not started");

endmodule

// ----- rtl/wwg_window.sv -----
// ----------------------------------------------------------------------------
// wwg_window
// Three-by-three neighbourhood window over the old grid. Holds the two
// previous columns of the rows above, at and below the cell and applies the
// wireworld rule to the centre cell.
// ----------------------------------------------------------------------------
module wwg_window
   import wwg_pkg::*;
(
   input  logic        clock,
   input  win_ctl_type ctl,
   input  cell_type    top_cell,
   input  cell_type    mid_cell,
   input  cell_type    bot_cell,
   output cell_type    new_cell
);

   cell_type top_left_ff, top_mid_ff;
   cell_type mid_left_ff, mid_mid_ff;
   cell_type bot_left_ff, bot_mid_ff;
   cell_type top_v, mid_v, bot_v;
   logic [3:0] heads;

   // cells beyond the active area never count
   always_comb begin
      top_v = (ctl.top_ok && !ctl.at_edge) ? top_cell : CELL_EMPTY;
      mid_v = (!ctl.at_edge) ? mid_cell : CELL_EMPTY;
      bot_v = (ctl.bot_ok && !ctl.at_edge) ? bot_cell : CELL_EMPTY;
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         top_left_ff <= ctl.restart ? CELL_EMPTY : top_mid_ff;
         mid_left_ff <= ctl.restart ? CELL_EMPTY : mid_mid_ff;
         bot_left_ff <= ctl.restart ? CELL_EMPTY : bot_mid_ff;
         top_mid_ff  <= top_v;
         mid_mid_ff  <= mid_v;
         bot_mid_ff  <= bot_v;
      end
   end

   always_comb begin
      heads = {3'd0, top_left_ff == CELL_HEAD} + {3'd0, top_mid_ff == CELL_HEAD}
            + {3'd0, top_v == CELL_HEAD}       + {3'd0, mid_left_ff == CELL_HEAD}
            + {3'd0, mid_v == CELL_HEAD}       + {3'd0, bot_left_ff == CELL_HEAD}
            + {3'd0, bot_mid_ff == CELL_HEAD}  + {3'd0, bot_v == CELL_HEAD};
   end

   always_comb begin
      case (mid_mid_ff)
         CELL_HEAD: new_cell = CELL_TAIL;
         CELL_TAIL: new_cell = CELL_WIRE;
         CELL_WIRE: new_cell = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_WIRE;
         default:   new_cell = CELL_EMPTY;
      endcase
   end

endmodule

// ----- tb/tb_wireworld_grid_engine.sv -----
// ----------------------------------------------------------------------------
// tb_wireworld_grid_engine
// Self-checking testbench of the wireworld grid engine. Command beats go in
// on the request channel in random bursts while the response channel stalls
// on a pattern of its own. A mirror of the cell grid and of the size
// registers predicts each response: cell writes and reads, rejected
// coordinates, runs of generations and the idle command code. Short directed
// tests cover the cleared store, the size limits and the wire rules. Random
// traffic then follows over a series of grid sizes.
// ----------------------------------------------------------------------------
module tb_wireworld_grid_engine;
   import wwg_pkg::*;

   localparam cmd_type CMD_NOP = 2'd3;

   typedef struct {
      cell_type cell_read;
      logic     status;
   } answer_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   wwg_req_if req_ch ();
   wwg_rsp_if rsp_ch ();

   wireworld_grid_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cell_type   cell_mirror [DEF_MAX_ROWS][DEF_MAX_COLS];
   logic [7:0] cols_reg;
   logic [4:0] rows_reg;
   answer_type answer_q [$];
   answer_type got_answer;

   int fail_count  = 0;
   int burst_left  = 0;
   int n_write     = 0;
   int n_read      = 0;
   int n_run       = 0;
   int n_nop       = 0;
   int n_reject    = 0;
   int gens_total  = 0;
   int rsp_count   = 0;
   int grid_writes = 0;
   int stall_mode  = 0;
   int stall_left  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- mirror

   function automatic int active_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
      return int'(cols_reg);
   endfunction

   function automatic int active_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
      return int'(rows_reg);
   endfunction

   function automatic void advance_generation(input int nr, input int nc);
      cell_type old_grid [DEF_MAX_ROWS][DEF_MAX_COLS];
      int heads;
      old_grid = cell_mirror;
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            case (old_grid[r][c])
               CELL_HEAD: cell_mirror[r][c] = CELL_TAIL;
               CELL_TAIL: cell_mirror[r][c] = CELL_WIRE;
               CELL_WIRE: begin
                  heads = 0;
                  for (int dr = -1; dr <= 1; dr++) begin
                     for (int dc = -1; dc <= 1; dc++) begin
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < nr &&
                            c + dc >= 0 && c + dc < nc &&
                            old_grid[r + dr][c + dc] == CELL_HEAD)
                           heads++;
                     end
                  end
                  if (heads == 1 || heads == 2) cell_mirror[r][c] = CELL_HEAD;
               end
               default: ;
            endcase
         end
      end
   endfunction

   function automatic answer_type apply_command(input cmd_type cmd, input logic [3:0] row,
                                                input logic [6:0] col, input cell_type val,
                                                input logic [7:0] gens);
      answer_type ans;
      int nr;
      int nc;
      ans.cell_read = CELL_EMPTY;
      ans.status    = 1'b0;
      nr = active_rows();
      nc = active_cols();
      case (cmd)
         CMD_WRITE, CMD_READ: begin
            if (row >= nr || col >= nc) ans.status = 1'b1;
            else if (cmd == CMD_WRITE) cell_mirror[row][col] = val;
            else ans.cell_read = cell_mirror[row][col];
         end
         CMD_RUN: begin
            for (int g = 0; g < gens; g++) advance_generation(nr, nc);
         end
         default: ;
      endcase
      return ans;
   endfunction

   // ------------------------------------------------------------- drivers

   task automatic send_cmd(input cmd_type cmd, input logic [3:0] row, input logic [6:0] col,
                           input cell_type val, input logic [7:0] gens);
      answer_type ans;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(10, 1)) @(posedge clock);
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) :
                                                  $urandom_range(8, 1);
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.row         <= row;
      req_ch.col         <= col;
      req_ch.cell_value  <= val;
      req_ch.generations <= gens;
      do @(posedge clock); while (!req_ch.ready);
      ans = apply_command(cmd, row, col, val, gens);
      answer_q.push_back(ans);
      if (ans.status) n_reject++;
      case (cmd)
         CMD_WRITE: n_write++;
         CMD_READ:  n_read++;
         CMD_RUN: begin
            n_run++;
            gens_total += int'(gens);
         end
         default:   n_nop++;
      endcase
   endtask

   task automatic do_write(input logic [3:0] row, input logic [6:0] col, input cell_type val);
      send_cmd(CMD_WRITE, row, col, val, 8'($urandom_range(255, 0)));
   endtask

   task automatic do_read(input logic [3:0] row, input logic [6:0] col);
      send_cmd(CMD_READ, row, col, cell_type'($urandom_range(3, 0)),
               8'($urandom_range(255, 0)));
   endtask

   task automatic do_run(input logic [7:0] gens);
      send_cmd(CMD_RUN, 4'($urandom_range(15, 0)), 7'($urandom_range(127, 0)),
               cell_type'($urandom_range(3, 0)), gens);
   endtask

   task automatic do_nop();
      send_cmd(CMD_NOP, 4'($urandom_range(15, 0)), 7'($urandom_range(127, 0)),
               cell_type'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
   endtask

   // sender holds off until every response is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [7:0] cols_raw, input logic [7:0] rows_raw);
      csr_we    <= 1'b1;
      csr_index <= CSR_COLS;
      csr_wdata <= cols_raw;
      @(posedge clock);
      cols_reg   = cols_raw;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows_raw;
      @(posedge clock);
      rows_reg   = rows_raw[4:0];
      csr_we    <= 1'b0;
      grid_writes++;
   endtask

   // -------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(3, 0);
         stall_left = $urandom_range(120, 20);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= 1'($urandom_range(1, 0));
         2:       rsp_ch.ready <= ($urandom_range(3, 0) == 0);
         default: rsp_ch.ready <= ($urandom_range(15, 0) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_count++;
         if (answer_q.size() == 0) begin
            $error("response beat with no command pending");
            fail_count++;
         end else begin
            got_answer = answer_q.pop_front();
            if (rsp_ch.cell_read !== got_answer.cell_read) begin
               $error("cell_read: expected %0d, actual %0d", got_answer.cell_read,
                      rsp_ch.cell_read);
               fail_count++;
            end
            if (rsp_ch.status !== got_answer.status) begin
               $error("status: expected %0d, actual %0d", got_answer.status, rsp_ch.status);
               fail_count++;
            end
         end
      end
   end

   // ----------------------------------------------------------------- tests

   task automatic test_cleared_store();
      do_read(4'd0, 7'd0);
      do_read(4'd15, 7'd127);
   endtask

   task automatic test_cell_access();
      do_write(4'd15, 7'd127, CELL_TAIL);
      do_read(4'd15, 7'd127);
      do_write(4'd0, 7'd0, CELL_HEAD);
      do_read(4'd0, 7'd0);
      do_write(4'd1, 7'd5, CELL_HEAD);
      do_nop();
   endtask

   task automatic test_size_limits();
      drain();
      set_grid(8'd0, 8'd0);
      do_write(4'd0, 7'd1, CELL_WIRE);
      do_read(4'd1, 7'd0);
      do_write(4'd0, 7'd0, CELL_WIRE);
      do_read(4'd0, 7'd0);
      drain();
      set_grid(8'd255, 8'd255);
      do_read(4'd0, 7'd0);
   endtask

   // head inside the grid sits next to an active conductor
   task automatic test_wire_rules();
      drain();
      set_grid(8'd5, 8'd3);
      do_write(4'd1, 7'd1, CELL_HEAD);
      do_write(4'd1, 7'd2, CELL_WIRE);
      do_write(4'd1, 7'd4, CELL_WIRE);
      do_write(4'd2, 7'd4, CELL_WIRE);
      do_run(8'd0);
      do_run(8'd1);
      do_read(4'd1, 7'd2);
      do_read(4'd1, 7'd4);
      do_run(8'd255);
      do_read(4'd1, 7'd2);
   endtask

   task automatic test_full_grid_run();
      drain();
      set_grid(8'd128, 8'd16);
      do_run(8'd1);
      do_read(4'd1, 7'd5);
      do_read(4'd15, 7'd127);
   endtask

   task automatic test_random_traffic();
      int p;
      int cols_raw;
      int rows_raw;
      int nr;
      int nc;
      int cost;
      int pick;
      int vpick;
      logic [3:0] r;
      logic [6:0] c;
      cell_type v;
      logic [7:0] g;
      for (p = 0; p < 12; p++) begin
         case (p)
            0: begin cols_raw = 128; rows_raw = 16; end
            1: begin cols_raw = 0;   rows_raw = 0;  end
            2: begin cols_raw = 128; rows_raw = 1;  end
            3: begin cols_raw = 1;   rows_raw = 31; end
            4: begin cols_raw = 200; rows_raw = 3;  end
            5: begin cols_raw = 3;   rows_raw = 2;  end
            default: begin
               cols_raw = $urandom_range(12, 1);
               rows_raw = $urandom_range(6, 1);
            end
         endcase
         drain();
         set_grid(8'(cols_raw), 8'(rows_raw));
         nr = active_rows();
         nc = active_cols();
         cost = (nr + 1) * (nc + 1) + 1;
         repeat (22) begin
            pick = $urandom_range(99, 0);
            r = 4'($urandom_range(nr - 1, 0));
            c = 7'($urandom_range(nc - 1, 0));
            if (pick < 45) begin
               vpick = $urandom_range(99, 0);
               v = (vpick < 50) ? CELL_WIRE : (vpick < 70) ? CELL_HEAD :
                   (vpick < 85) ? CELL_TAIL : CELL_EMPTY;
               do_write(r, c, v);
            end else if (pick < 72) begin
               do_read(r, c);
            end else if (pick < 84) begin
               if (cost > 300) g = 8'($urandom_range(2, 0));
               else if (cost <= 40 && $urandom_range(7, 0) == 0) g = 8'($urandom_range(255, 0));
               else g = 8'($urandom_range(6, 0));
               do_run(g);
            end else if (pick < 92 && (nr < DEF_MAX_ROWS || nc < DEF_MAX_COLS)) begin
               // coordinate off the active grid
               if (nc < DEF_MAX_COLS && (nr == DEF_MAX_ROWS || $urandom_range(1, 0) == 1)) begin
                  r = 4'($urandom_range(15, 0));
                  c = 7'($urandom_range(127, nc));
               end else begin
                  r = 4'($urandom_range(15, nr));
                  c = 7'($urandom_range(127, 0));
               end
               if ($urandom_range(1, 0) == 1) do_write(r, c, cell_type'($urandom_range(3, 0)));
               else do_read(r, c);
            end else if (pick < 92) begin
               do_read(r, c);
            end else begin
               do_nop();
            end
         end
      end
   endtask

   // ------------------------------------------------------------------ main

   initial begin
      reset              = 1'b1;
      cols_reg           = COLS_RESET;
      rows_reg           = ROWS_RESET;
      csr_we             = 1'b0;
      csr_index          = CSR_COLS;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_WRITE;
      req_ch.row         = '0;
      req_ch.col         = '0;
      req_ch.cell_value  = CELL_EMPTY;
      req_ch.generations = '0;
      for (int r = 0; r < DEF_MAX_ROWS; r++)
         for (int c = 0; c < DEF_MAX_COLS; c++)
            cell_mirror[r][c] = CELL_EMPTY;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_cleared_store();
      test_cell_access();
      test_size_limits();
      test_wire_rules();
      test_full_grid_run();
      test_random_traffic();

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d command beats: %0d writes, %0d reads, %0d runs, %0d idle codes",
               n_write + n_read + n_run + n_nop, n_write, n_read, n_run, n_nop);
      $display("%0d grid settings, %0d generations, %0d off-grid rejections, %0d responses",
               grid_writes, gens_total, n_reject, rsp_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
